// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the lru key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
   localparam logic [DATA_W-1:0]  MISS_VALUE  = '1;

   localparam logic KIND_PUT = 1'b0;
   localparam logic KIND_GET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;     // capture request beat
      logic lookup;   // key compare, pick target slot
      logic update;   // write slot, shift recency list
      logic respond;  // emit a result beat
   } cmd_type;

   typedef struct packed {
      logic is_get;
   } status_type;

endpackage

// ===== sv/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: lookup cycle followed by update cycle for each request.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lkvc_pkg::status_type   status,
   output lkvc_pkg::cmd_type      cmd
);
   import lkvc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            busy       = 1'b1;
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // the next request may be taken while this one writes back
            cmd.update  = 1'b1;
            cmd.respond = status.is_get;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/lkvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key/value slots, recency list, fill count, limit register and result regs.
// ----------------------------------------------------------------------------
module lkvc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cmd_type             cmd,
   output lkvc_pkg::status_type          status,
   input  logic                          cfg_we,
   input  logic [lkvc_pkg::LIMIT_W-1:0]  cfg_limit,
   input  logic                          req_kind,
   input  logic signed [lkvc_pkg::KEY_W-1:0]  req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_data,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic signed [lkvc_pkg::DATA_W-1:0] rsp_read_value
);
   import lkvc_pkg::*;

   // request capture
   logic              kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;

   // lookup results
   logic              hit_ff, hit_in;
   logic              room_ff, room_in;
   logic [IDX_W-1:0]  target_ff, target_in;
   logic [DATA_W-1:0] value_ff;

   // storage
   logic [KEY_W-1:0]  keys_ff   [DEPTH];
   logic [DATA_W-1:0] values_ff [DEPTH];
   logic [IDX_W-1:0]  order_ff  [DEPTH];
   logic [IDX_W-1:0]  order_in  [DEPTH];
   logic [CNT_W-1:0]  fill_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic              rsp_strobe_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [CNT_W-1:0]  lim_eff;
   logic              found;
   logic [IDX_W-1:0]  match_idx;
   logic [CNT_W-1:0]  last_pos;
   logic [IDX_W-1:0]  shift_from;
   logic              do_promote;
   logic              do_write;

   assign status.is_get = (kind_ff == KIND_GET);

   // limit of zero acts as one, above depth saturates
   always_comb begin
      if (int'(limit_ff) > DEPTH) begin
         lim_eff = CNT_W'(DEPTH);
      end else if (limit_ff == '0) begin
         lim_eff = CNT_W'(1);
      end else begin
         lim_eff = CNT_W'(limit_ff);
      end
   end

   // parallel compare over filled slots, lowest index wins
   always_comb begin
      found     = 1'b0;
      match_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (CNT_W'(i) < fill_ff && keys_ff[i] == key_ff) begin
            found     = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
      hit_in  = found;
      room_in = (fill_ff < lim_eff);
      if (found) begin
         target_in = match_idx;
      end else if (room_in) begin
         target_in = fill_ff[IDX_W-1:0];
      end else begin
         target_in = order_ff[0];
      end
   end

   // move target slot to the most recent end of the list
   always_comb begin
      last_pos   = fill_ff - CNT_W'(1);
      shift_from = last_pos[IDX_W-1:0];
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (CNT_W'(i) < fill_ff && order_ff[i] == target_ff) begin
            shift_from = IDX_W'(i);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         order_in[i] = order_ff[i];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (IDX_W'(i) >= shift_from && CNT_W'(i + 1) < fill_ff) begin
            order_in[i] = order_ff[i + 1];
         end
      end
      order_in[last_pos[IDX_W-1:0]] = target_ff;
   end

   assign do_promote = cmd.update && (hit_ff || (kind_ff == KIND_PUT && !room_ff));
   assign do_write   = cmd.update && kind_ff == KIND_PUT;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         data_ff <= req_data;
      end
      if (cmd.lookup) begin
         hit_ff    <= hit_in;
         room_ff   <= room_in;
         target_ff <= target_in;
         value_ff  <= values_ff[match_idx];
      end
      if (do_write) begin
         values_ff[target_ff] <= data_ff;
         if (!hit_ff) begin
            keys_ff[target_ff] <= key_ff;
         end
      end
      if (do_promote) begin
         order_ff <= order_in;
      end else if (do_write && !hit_ff && room_ff) begin
         order_ff[target_ff] <= target_ff;
      end
      if (cmd.respond) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? value_ff : MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         limit_ff      <= LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (cfg_we) begin
            limit_ff <= cfg_limit;
         end
         if (do_write && !hit_ff && room_ff) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative 16-entry key/value cache with lru replacement.
// ----------------------------------------------------------------------------
// Request channel: a beat is taken at a clock edge with start high and busy
// low. req_kind selects put (store req_data under req_key) or get (lookup).
// Each request passes through the parallel key compare (lookup state) and then
// the write-back / recency shift (update state), and a new request can be taken
// during the write-back when start is held; busy is high only in the compare cycle.
// Result channel: a get produces one beat on rsp_hit / rsp_read_value,
// marked by rsp_strobe for exactly one cycle; the result registers load in the
// update state that follows the lookup. Puts produce no beat. A miss returns hit low
// and all ones. The receiver cannot stall; results are never held.
// Config channel: csr_valid / csr_ready write the entry limit (always ready);
// write only while no request is in flight. Zero acts as one, values above
// the depth act as the depth.
// Reset (synchronous, active high): cache empty, limit 16, no result pending.
// No clearing pass is needed: only slots below the fill count are used.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0]  req_data,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkvc_pkg::LIMIT_W-1:0]        csr_entry_limit
);
   import lkvc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lkvc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg_we         (csr_valid && csr_ready),
      .cfg_limit      (csr_entry_limit),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

endmodule

// ===== verif/lkvc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_checker
// Watches the request, result and limit channels of the lru key/value cache,
// keeps its own model of the cache contents and the recency list, and checks
// every result beat against the oldest predicted lookup.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_kind,
   input  logic signed [lkvc_pkg::KEY_W-1:0]  req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_data,
   input  logic                               rsp_strobe,
   input  logic                               rsp_hit,
   input  logic signed [lkvc_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lkvc_pkg::LIMIT_W-1:0]       csr_entry_limit,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 lookup_count,
   output int                                 hit_count
);
   import lkvc_pkg::*;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value;
   } lookup_result_type;

   lookup_result_type  expected_lookups[$];
   lookup_result_type  oldest;
   logic [KEY_W-1:0]   slot_key   [DEPTH];
   logic [DATA_W-1:0]  slot_value [DEPTH];
   logic [IDX_W-1:0]   recency    [DEPTH];
   logic [CNT_W-1:0]   fill;
   logic [LIMIT_W-1:0] limit_reg;

   function automatic int filled_slots();
      return (fill > DEPTH) ? DEPTH : int'(fill);
   endfunction

   // move a slot to the most recent end of the recency list
   task automatic make_most_recent(input int slot);
      int n;
      int k;
      n = filled_slots();
      if (n == 0) return;
      k = 0;
      while (k < n && recency[k] != slot) k++;
      if (k >= n) k = n - 1;
      for (; k + 1 < n; k++) recency[k] = recency[k + 1];
      recency[n - 1] = IDX_W'(slot);
   endtask

   task automatic cache_access(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] data);
      int                n;
      int                lim;
      int                slot;
      int                j;
      lookup_result_type res;
      n    = filled_slots();
      lim  = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
      slot = DEPTH;
      for (j = n - 1; j >= 0; j--) begin
         if (slot_key[j] == key) slot = j;
      end
      if (kind == KIND_GET) begin
         lookup_count++;
         if (slot < DEPTH) begin
            res.hit   = 1'b1;
            res.value = slot_value[slot];
            hit_count++;
            make_most_recent(slot);
         end else begin
            res.hit   = 1'b0;
            res.value = MISS_VALUE;
         end
         expected_lookups.push_back(res);
      end else if (slot < DEPTH) begin
         slot_value[slot] = data;
         make_most_recent(slot);
      end else if (n < lim) begin
         slot_key[n]   = key;
         slot_value[n] = data;
         recency[n]    = IDX_W'(n);
         fill          = CNT_W'(n + 1);
      end else begin
         // full: the least recent entry is replaced and becomes most recent
         slot             = recency[0];
         slot_key[slot]   = key;
         slot_value[slot] = data;
         make_most_recent(slot);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill         = '0;
         limit_reg    = LIMIT_RESET;
         fail_count   = 0;
         lookup_count = 0;
         hit_count    = 0;
         expected_lookups.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_lookups.size() == 0) begin
               $error("result beat with no lookup pending: hit %b read_value %h",
                      rsp_hit, rsp_read_value);
               fail_count++;
            end else begin
               oldest = expected_lookups.pop_front();
               if (rsp_hit !== oldest.hit) begin
                  $error("hit: expected %b, actual %b", oldest.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_read_value !== oldest.value) begin
                  $error("read_value: expected %h, actual %h", oldest.value,
                         rsp_read_value);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) limit_reg = csr_entry_limit;
         if (start && !busy) cache_access(req_kind, req_key, req_data);
      end
      pending_count = expected_lookups.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the lru key/value cache: a directed pass over
// corner keys, updates, misses and limit edge values, then random put/get
// traffic over small key pools under a range of entry limits.
// ----------------------------------------------------------------------------
module testbench;
   import lkvc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 250;
   localparam int POOL_MAX    = 24;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      start           = 1'b0;
   logic                      busy;
   logic                      req_kind        = KIND_PUT;
   logic signed [KEY_W-1:0]   req_key         = '0;
   logic signed [DATA_W-1:0]  req_data        = '0;
   logic                      rsp_strobe;
   logic                      rsp_hit;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [LIMIT_W-1:0]        csr_entry_limit = LIMIT_RESET;

   int fail_count;
   int pending_count;
   int lookup_count;
   int hit_count;
   int request_count = 0;
   int limit_writes  = 0;
   int cycle_count   = 0;
   int idle_pct      = 31;
   int pool_size;
   logic [KEY_W-1:0] key_pool [POOL_MAX];

   always #5 clock = ~clock;

   lru_key_value_cache_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_limit (csr_entry_limit)
   );

   lkvc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_limit (csr_entry_limit),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .lookup_count    (lookup_count),
      .hit_count       (hit_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_key_value_cache_top: mismatch");
         $finish;
      end
   end

   // hold start until the beat is taken, then maybe drop it and randomize the request fields
   task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                            input logic [DATA_W-1:0] data);
      int gap;
      start    <= 1'b1;
      req_kind <= kind;
      req_key  <= key;
      req_data <= data;
      do @(posedge clock); while (busy);
      request_count++;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start    <= 1'b0;
         req_kind <= 1'($urandom_range(1));
         req_key  <= $urandom();
         req_data <= $urandom();
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait out every lookup plus the tail of any put still in the pipe
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_entry_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int idle);
      int               eff;
      int               pick;
      int               i;
      logic [KEY_W-1:0] key;
      settle();
      write_limit(limit);
      idle_pct  = idle;
      eff       = (limit == 0) ? 1 : ((limit > DEPTH) ? DEPTH : int'(limit));
      pool_size = eff + $urandom_range(1, 4);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom();
      repeat (PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            key = key_pool[$urandom_range(pool_size - 1)];
         end else if (pick < 90) begin
            case ($urandom_range(2))
               0: key = '0;
               1: key = '1;
               default: key = {1'b1, {(KEY_W-1){1'b0}}};
            endcase
         end else begin
            key = $urandom();
         end
         send_item($urandom_range(1) ? KIND_GET : KIND_PUT, key, $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache, corner keys and values, update of a present key
      send_item(KIND_GET, '0, $urandom());
      send_item(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_item(KIND_PUT, '1, '0);
      send_item(KIND_GET, 32'h8000_0000, $urandom());
      send_item(KIND_GET, 32'h7fff_ffff, $urandom());
      send_item(KIND_GET, '1, $urandom());
      send_item(KIND_PUT, '1, '1);
      send_item(KIND_GET, '1, $urandom());
      send_item(KIND_GET, '0, $urandom());
      send_item(KIND_GET, 32'hffff_fffe, $urandom());

      // zero limit acts as one, contents kept, new keys evict the lru entry
      settle();
      write_limit('0);
      send_item(KIND_PUT, 32'h1234_5678, 32'h5a5a_5a5a);
      send_item(KIND_GET, 32'h8000_0000, $urandom());
      send_item(KIND_GET, 32'h7fff_ffff, $urandom());
      send_item(KIND_GET, 32'h1234_5678, $urandom());
      send_item(KIND_PUT, '0, '0);
      send_item(KIND_GET, '1, $urandom());

      // limit above the depth saturates
      settle();
      write_limit('1);
      send_item(KIND_PUT, 32'h0000_0001, 32'h0000_0001);
      send_item(KIND_GET, 32'h0000_0001, $urandom());
      send_item(KIND_GET, '0, $urandom());

      // fill only grows, so small limits come first
      run_phase(5'd1, 31);
      run_phase(5'd2, 31);
      run_phase(5'd4, 31);
      run_phase(5'd8, 0);
      run_phase(5'd31, 31);
      run_phase(5'd16, 31);
      run_phase(5'd0, 31);
      run_phase(LIMIT_W'($urandom_range(31)), 31);

      settle();
      if (pending_count != 0) $error("%0d lookup results never arrived", pending_count);
      $display("covered %0d requests, %0d lookups with %0d hits", request_count,
               lookup_count, hit_count);
      $display("over %0d entry limit writes, zero and saturating values included",
               limit_writes);
      if (fail_count == 0 && pending_count == 0) begin
         $display("lru_key_value_cache_top: match");
      end else begin
         $display("lru_key_value_cache_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== lru_key_value_cache_top.f =====
sv/lkvc_pkg.sv
sv/lkvc_ctrl.sv
sv/lkvc_datapath.sv
sv/lru_key_value_cache_top.sv
verif/lkvc_checker.sv
verif/testbench.sv
